FILE: hw/rtl/bpb_pkg.sv
// Shared types and constants for the binary to packed BCD converter.
package bpb_pkg;

	localparam int VALUE_W        = 64;  // binary input width
	localparam int COUNT_W        = 4;   // byte count field width
	localparam int DIGIT_W        = 4;   // one BCD digit
	localparam int BYTE_W         = 8;   // two digits per output byte
	localparam int DIGIT_FIX_MIN  = 5;   // digit value that needs the +3 fix before a shift
	localparam int DIGIT_FIX_ADD  = 3;
	localparam int BITS_PER_STEP  = 8;   // binary bits folded in per converter cycle
	localparam int CONV_STEPS     = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W         = $clog2(CONV_STEPS);

	// Input item
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] byte_count;
	} num_t;

	// Result item
	typedef struct packed {
		logic [BYTE_W-1:0] bcd_byte;
		logic              last;
	} bcd_t;

	// Queue status seen by the front end and the converter
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hw/rtl/bpb_front.sv
// Front end: accepts items, clamps the byte count and drops empty runs.
module bpb_front #(
	parameter int MAX_BYTES = 10
) (
	input  logic           num_valid,
	output logic           num_stall,
	input  bpb_pkg::num_t  num,
	input  bpb_pkg::q_stat_t q_stat,
	output logic           push,
	output bpb_pkg::num_t  push_item
);
	import bpb_pkg::*;

	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_BYTES);

	logic [COUNT_W-1:0] cnt_sat;

	// Clamp the count; a zero count yields nothing and never enters the queue
	always_comb begin
		cnt_sat = (num.byte_count > MAX_CNT) ? MAX_CNT : num.byte_count;
		push_item.value      = num.value;
		push_item.byte_count = cnt_sat;
	end

	assign num_stall = q_stat.full;
	assign push      = num_valid && !q_stat.full && (cnt_sat != '0);

endmodule

FILE: hw/rtl/bpb_fifo.sv
// Two-entry item queue between the front end and the converter.
module bpb_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bpb_pkg::num_t    push_item,
	input  logic             pop,
	output bpb_pkg::num_t    head,
	output bpb_pkg::q_stat_t q_stat
);
	import bpb_pkg::*;

	num_t ent_q [2];
	logic [1:0] v_q;

	// Valid bits: entry 0 is always the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (push && pop) begin
			v_q <= v_q;
		end else if (push) begin
			if (!v_q[0]) v_q[0] <= 1'b1;
			else         v_q[1] <= 1'b1;
		end else if (pop) begin
			v_q[0] <= v_q[1];
			v_q[1] <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (v_q[1]) begin
				ent_q[0] <= ent_q[1];
				ent_q[1] <= push_item;
			end else begin
				ent_q[0] <= push_item;
			end
		end else if (push) begin
			if (!v_q[0]) ent_q[0] <= push_item;
			else         ent_q[1] <= push_item;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
	end

	assign head         = ent_q[0];
	assign q_stat.full  = v_q[1];
	assign q_stat.empty = !v_q[0];

`ifndef ASSERT_OFF
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[1] |-> v_q[0])
		else $error("queue second entry valid without a head");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!v_q[1] || pop))
		else $error("queue written while full");
`endif

endmodule

FILE: hw/rtl/bpb_conv.sv
// Converter: shift-and-add-3 binary to BCD, eight binary bits per cycle.
module bpb_conv #(
	parameter int MAX_BYTES = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpb_pkg::num_t                 head,
	input  bpb_pkg::q_stat_t              q_stat,
	output logic                          pop,
	output logic                          res_valid,
	input  logic                          res_take,
	output logic [8*MAX_BYTES-1:0]        res_bcd,
	output logic [bpb_pkg::COUNT_W-1:0]   res_cnt
);
	import bpb_pkg::*;

	localparam int BCD_W  = BYTE_W * MAX_BYTES;
	localparam int DIGITS = BCD_W / DIGIT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_q;
	logic [VALUE_W-1:0]   bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [BCD_W-1:0]     bcd_nx;

	// Eight rounds of digit correction and shift; digits above the top are dropped
	always_comb begin
		bcd_nx = bcd_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_nx[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(DIGIT_FIX_MIN))
					bcd_nx[d*DIGIT_W +: DIGIT_W] =
						bcd_nx[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(DIGIT_FIX_ADD);
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], bin_q[VALUE_W-1-s]};
		end
	end

	// Take the next item when idle or as the finished one is handed over
	assign pop = !q_stat.empty && ((state_q == S_IDLE) || ((state_q == S_DONE) && res_take));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			bin_q   <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE, S_DONE: begin
					if (pop) begin
						state_q <= S_RUN;
						step_q  <= '0;
						bin_q   <= head.value;
						bcd_q   <= '0;
						cnt_q   <= head.byte_count;
					end else if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				S_RUN: begin
					bcd_q  <= bcd_nx;
					bin_q  <= bin_q << BITS_PER_STEP;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CONV_STEPS-1)) state_q <= S_DONE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = (state_q == S_DONE);
	assign res_bcd   = bcd_q;
	assign res_cnt   = cnt_q;

`ifndef ASSERT_OFF
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && step_q == STEP_W'(CONV_STEPS-1)) |=> (state_q == S_DONE))
		else $error("conversion did not finish after the last step");
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> (state_q == S_DONE))
		else $error("result taken while conversion not finished");
`endif

endmodule

FILE: hw/rtl/bpb_emit.sv
// Back end: holds one converted run and sends it out a byte per cycle while bcd_stall is low.
module bpb_emit #(
	parameter int MAX_BYTES = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	output logic                          res_take,
	input  logic [8*MAX_BYTES-1:0]        res_bcd,
	input  logic [bpb_pkg::COUNT_W-1:0]   res_cnt,
	output logic                          bcd_valid,
	input  logic                          bcd_stall,
	output bpb_pkg::bcd_t                 bcd
);
	import bpb_pkg::*;

	localparam int BCD_W  = BYTE_W * MAX_BYTES;
	localparam int LEFT_W = $clog2(MAX_BYTES + 1);

	logic [LEFT_W-1:0] left_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              acc;
	logic              free;

	assign acc      = bcd_valid && !bcd_stall;
	// Free when empty or when the last byte leaves this cycle
	assign free     = (left_q == '0) || ((left_q == LEFT_W'(1)) && acc);
	assign res_take = res_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (res_take) begin
			left_q <= LEFT_W'(res_cnt);
		end else if (acc) begin
			left_q <= left_q - 1'b1;
		end
	end

	// Run data, lowest byte at the bottom
	always_ff @(posedge clk) begin
		if (res_take)  bcd_q <= res_bcd;
		else if (acc)  bcd_q <= bcd_q >> BYTE_W;
	end

	assign bcd_valid    = (left_q != '0);
	assign bcd.bcd_byte = bcd_q[BYTE_W-1:0];
	assign bcd.last     = (left_q == LEFT_W'(1));

`ifndef ASSERT_OFF
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= LEFT_W'(MAX_BYTES))
		else $error("byte counter above limit");
	a_run_goes_on: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !bcd.last) |=> bcd_valid)
		else $error("run ended without a last byte");
`endif

endmodule

FILE: hw/rtl/binary_to_packed_bcd_core.sv
// Top level of the binary to packed BCD converter.
//
//  channel | valid     | stall     | payload         | items
//  --------+-----------+-----------+-----------------+------------------------------
//  num     | num_valid | num_stall | num (num_t)     | value, byte_count
//  bcd     | bcd_valid | bcd_stall | bcd (bcd_t)     | bcd_byte, last; LSB byte first
//
// An item is written into the queue and then loaded into the converter, which folds in
// eight binary bits per cycle; the finished run is handed over from the done state once
// the back end is free, and the back end's byte counter then marks its first byte valid.
// Output bytes leave one per cycle while bcd_stall is low, as the next item converts.
// A zero byte count is accepted whenever the queue has room and gives no output.
// arst_n clears the queue, the converter state and the byte counter.
// num_stall rises only while the two-entry queue is full.
module binary_to_packed_bcd_core #(
	parameter int MAX_BYTES = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           num_valid,
	output logic           num_stall,
	input  bpb_pkg::num_t  num,
	output logic           bcd_valid,
	input  logic           bcd_stall,
	output bpb_pkg::bcd_t  bcd
);
	import bpb_pkg::*;

	logic                    push;
	num_t                    push_item;
	logic                    pop;
	num_t                    head;
	q_stat_t                 q_stat;
	logic                    res_valid;
	logic                    res_take;
	logic [8*MAX_BYTES-1:0]  res_bcd;
	logic [COUNT_W-1:0]      res_cnt;

	bpb_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.num_valid (num_valid),
		.num_stall (num_stall),
		.num       (num),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	bpb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	bpb_conv #(.MAX_BYTES(MAX_BYTES)) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_bcd   (res_bcd),
		.res_cnt   (res_cnt)
	);

	bpb_emit #(.MAX_BYTES(MAX_BYTES)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_bcd   (res_bcd),
		.res_cnt   (res_cnt),
		.bcd_valid (bcd_valid),
		.bcd_stall (bcd_stall),
		.bcd       (bcd)
	);

endmodule

FILE: verif/tb_binary_to_packed_bcd_core.sv
// Self-checking testbench for the binary to packed BCD converter core.
module tb_binary_to_packed_bcd_core;
	import bpb_pkg::*;

	localparam int MAX_BYTES    = 10;
	localparam int RADIX        = 10;
	localparam int IDLE_MAX     = 12;
	localparam int RANDOM_ITEMS = 500;
	localparam int STUCK_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [VALUE_W-1:0] ALL_ONES  = '1;
	localparam logic [VALUE_W-1:0] MIXED_NUM = 64'd12345678901234567890;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic num_valid = 1'b0;
	logic num_stall;
	num_t num       = '0;
	logic bcd_valid;
	logic bcd_stall = 1'b0;
	bcd_t bcd;

	num_t pending_nums[$];
	bcd_t expected_bcd[$];

	int send_gap      = 0;
	int send_calm     = 0;
	int stall_left    = 0;
	int stall_calm    = 0;
	int stuck_cycles  = 0;
	int error_count   = 0;
	int sent_items    = 0;
	int checked_bytes = 0;
	int empty_items   = 0;
	int capped_items  = 0;
	logic timed_out;

	always #1 clk = ~clk;

	binary_to_packed_bcd_core #(
		.MAX_BYTES(MAX_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_stall(num_stall),
		.num      (num),
		.bcd_valid(bcd_valid),
		.bcd_stall(bcd_stall),
		.bcd      (bcd)
	);

	// Idle cycles before the next item; calm stretches give back-to-back traffic
	function automatic int draw_idle(inout int calm_run);
		if (calm_run > 0) begin
			calm_run--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_run = $urandom_range(10, 40);
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
	endfunction

	// Expected packed BCD bytes for one accepted number, low byte first
	function automatic void to_packed_bcd(num_t item);
		logic [VALUE_W-1:0] rest;
		logic [VALUE_W-1:0] digit;
		int n_bytes;
		bcd_t b;
		rest = item.value;
		n_bytes = item.byte_count;
		if (n_bytes == 0)
			empty_items++;
		if (n_bytes > MAX_BYTES) begin
			n_bytes = MAX_BYTES;
			capped_items++;
		end
		for (int k = 0; k < n_bytes; k++) begin
			digit = rest % RADIX;
			b.bcd_byte[DIGIT_W-1:0] = digit[DIGIT_W-1:0];
			rest = rest / RADIX;
			digit = rest % RADIX;
			b.bcd_byte[BYTE_W-1:DIGIT_W] = digit[DIGIT_W-1:0];
			rest = rest / RADIX;
			b.last = (k == n_bytes - 1);
			expected_bcd.push_back(b);
		end
	endfunction

	task automatic queue_num(input logic [VALUE_W-1:0] v, input int count);
		num_t item;
		item.value = v;
		item.byte_count = count[COUNT_W-1:0];
		pending_nums.push_back(item);
	endtask

	// Number driver: presents queued items, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_valid <= 1'b0;
			send_gap = 0;
		end else if (num_valid && !num_stall) begin
			to_packed_bcd(num);
			sent_items++;
			send_gap = draw_idle(send_calm);
			if (send_gap == 0 && pending_nums.size() != 0) begin
				num <= pending_nums.pop_front();
			end else begin
				num_valid <= 1'b0;
				if (send_gap > 0)
					send_gap--;
			end
		end else if (!num_valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_nums.size() != 0) begin
				num <= pending_nums.pop_front();
				num_valid <= 1'b1;
			end
		end
	end

	// BCD monitor: random back-pressure and field checks
	always @(posedge clk or negedge arst_n) begin : bcd_monitor
		bcd_t want;
		if (!arst_n) begin
			bcd_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (bcd_valid && !bcd_stall) begin
				if (expected_bcd.size() == 0) begin
					$error("unexpected bcd item: bcd_byte %h last %b", bcd.bcd_byte, bcd.last);
					error_count++;
				end else begin
					want = expected_bcd.pop_front();
					if (bcd.bcd_byte !== want.bcd_byte) begin
						$error("bcd_byte: expected %h, got %h", want.bcd_byte, bcd.bcd_byte);
						error_count++;
					end
					if (bcd.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, bcd.last);
						error_count++;
					end
					checked_bytes++;
				end
				stall_left = draw_idle(stall_calm);
			end
			if (stall_left > 0) begin
				bcd_stall <= 1'b1;
				stall_left--;
			end else begin
				bcd_stall <= 1'b0;
			end
		end
	end

	// Watchdog: consecutive cycles with work outstanding and no item moving
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stuck_cycles <= 0;
		else if ((num_valid && !num_stall) || (bcd_valid && !bcd_stall) ||
				(pending_nums.size() == 0 && !num_valid && expected_bcd.size() == 0))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] p;
		int count;
		int pick;

		// Directed: every byte count including zero and the saturated range
		for (int i = 0; i < 16; i++)
			queue_num((i % 2 != 0) ? ALL_ONES : MIXED_NUM, i);
		// Leading zeros, dropped upper digits, nines and powers of ten
		queue_num('0, MAX_BYTES);
		queue_num(64'd99, 1);
		queue_num(64'd100, 1);
		queue_num(64'd9999999999999999999, MAX_BYTES);
		queue_num(64'd10000000000000000000, MAX_BYTES);
		queue_num(64'h8000_0000_0000_0000, MAX_BYTES);
		queue_num(64'd1, 3);

		// Random numbers of mixed magnitude
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 3);
			case (pick)
				0: v = {$urandom, $urandom};
				1: v = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
				2: begin
					p = 1;
					repeat ($urandom_range(0, 19)) p = p * RADIX;
					v = p - $urandom_range(0, 1);
				end
				default: v = $urandom_range(0, 9999);
			endcase
			pick = $urandom_range(0, 19);
			if (pick == 0)
				count = 0;
			else if (pick < 3)
				count = $urandom_range(MAX_BYTES + 1, 15);
			else
				count = $urandom_range(1, MAX_BYTES);
			queue_num(v, count);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (!(pending_nums.size() == 0 && !num_valid && expected_bcd.size() == 0) &&
				stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		timed_out = (stuck_cycles >= STUCK_LIMIT);
		if (!timed_out)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (timed_out) begin
			$display("no progress for %0d cycles, %0d bytes still due",
				STUCK_LIMIT, expected_bcd.size());
			$display("tb_binary_to_packed_bcd_core: FAIL");
		end else begin
			$display("converted %0d numbers: %0d with zero count, %0d with count above %0d",
				sent_items, empty_items, capped_items, MAX_BYTES);
			$display("checked %0d packed BCD bytes, %0d mismatches", checked_bytes, error_count);
			if (error_count == 0)
				$display("tb_binary_to_packed_bcd_core: PASS");
			else
				$display("tb_binary_to_packed_bcd_core: FAIL");
		end
		$finish;
	end

endmodule
